// File: rtl/trp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// trp_pkg
// Types, codes and lookup functions shared by the table response parser.
// ============================================================================
package trp_pkg;

    typedef enum logic [3:0] {
        PH_CNT_HI,
        PH_CNT_LO,
        PH_KIND,
        PH_NAME_LEN,
        PH_NAME,
        PH_FCOUNT,
        PH_FNAME_LEN,
        PH_FNAME,
        PH_FTYPE,
        PH_VALUE,
        PH_STR_LEN,
        PH_STR,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        EV_NAME_BYTE,
        EV_HEADER,
        EV_FNAME_BYTE,
        EV_FIELD_TYPE,
        EV_SCALAR,
        EV_STR_LEN,
        EV_STR_BYTE,
        EV_END
    } event_t;

    localparam logic [3:0] VT_UNDEF  = 4'd0;
    localparam logic [3:0] VT_INT8   = 4'd1;
    localparam logic [3:0] VT_INT16  = 4'd2;
    localparam logic [3:0] VT_INT32  = 4'd3;
    localparam logic [3:0] VT_INT64  = 4'd4;
    localparam logic [3:0] VT_FLOAT  = 4'd5;
    localparam logic [3:0] VT_DOUBLE = 4'd6;
    localparam logic [3:0] VT_BOOL   = 4'd7;
    localparam logic [3:0] VT_STRING = 4'd8;

    localparam logic [7:0] DB_TINYINT_A  = 8'hFA;
    localparam logic [7:0] DB_TINYINT_B  = 8'h01;
    localparam logic [7:0] DB_INT        = 8'h04;
    localparam logic [7:0] DB_BIGINT_A   = 8'hFB;
    localparam logic [7:0] DB_BIGINT_B   = 8'd93;
    localparam logic [7:0] DB_FLOAT_A    = 8'h06;
    localparam logic [7:0] DB_FLOAT_B    = 8'h07;
    localparam logic [7:0] DB_DOUBLE     = 8'h08;
    localparam logic [7:0] DB_BOOL_A     = 8'hF9;
    localparam logic [7:0] DB_BOOL_B     = 8'd16;
    localparam logic [7:0] DB_STRING     = 8'd12;
    localparam logic [7:0] DB_SMALLINT   = 8'h05;

    localparam logic [30:0] STR_LEN_BYTES = 31'd4;

    typedef struct packed {
        logic [6:0] field;
        logic [3:0] vtype;
    } trp_entry_t;

    typedef struct packed {
        logic        emit;
        event_t      ev;
        logic [63:0] value;
        logic [15:0] record_count;
        logic [7:0]  response_kind;
        logic [14:0] record_index;
        logic [6:0]  field_index;
        logic [3:0]  value_type;
        logic        done;
    } trp_result_t;

    function automatic logic [3:0] map_type(input logic [7:0] code);
        logic [3:0] vt;
        vt = VT_UNDEF;
        case (code) inside
            DB_TINYINT_A, DB_TINYINT_B: vt = VT_INT8;
            DB_INT:                     vt = VT_INT32;
            DB_BIGINT_A, DB_BIGINT_B:   vt = VT_INT64;
            DB_FLOAT_A, DB_FLOAT_B:     vt = VT_FLOAT;
            DB_DOUBLE:                  vt = VT_DOUBLE;
            DB_BOOL_A, DB_BOOL_B:       vt = VT_BOOL;
            DB_STRING:                  vt = VT_STRING;
            DB_SMALLINT:                vt = VT_INT16;
            default:                    vt = VT_UNDEF;
        endcase
        return vt;
    endfunction

    function automatic logic [30:0] type_width(input logic [3:0] vt);
        logic [30:0] w;
        case (vt) inside
            VT_INT8, VT_BOOL:     w = 31'd1;
            VT_INT16:             w = 31'd2;
            VT_INT32, VT_FLOAT:   w = 31'd4;
            VT_INT64, VT_DOUBLE:  w = 31'd8;
            default:              w = 31'd0;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/trp_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// trp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module trp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/trp_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// trp_parser
// Message state and one-byte parse step; keeps the list of known-type fields
// in a RAM and prefetches the entry that follows the current field.
// ============================================================================
module trp_parser
    import trp_pkg::*;
#(
    parameter int MAX_FIELDS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output trp_result_t res
);

    localparam int AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam logic [6:0] FCAP = (MAX_FIELDS > 127) ? 7'd127 : 7'(MAX_FIELDS);

    phase_t      phase_reg, phase_next;
    logic [30:0] bytes_left_reg, bytes_left_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  kind_reg, kind_next;
    logic [6:0]  nfields_reg, nfields_next;
    logic [6:0]  field_reg, field_next;
    logic [14:0] record_reg, record_next;
    logic [3:0]  ftype_reg, ftype_next;
    logic [6:0]  known_reg, known_next;
    logic [6:0]  pos_reg, pos_next;
    trp_entry_t  first_reg, first_next;
    logic [63:0] acc_reg, acc_next;
    logic        fwd_hit_reg, fwd_hit_next;
    trp_entry_t  fwd_data_reg;

    phase_t      ph;
    logic [30:0] bl;
    logic [15:0] cnt;
    logic [7:0]  kind;
    logic [6:0]  nfld;
    logic [6:0]  cfld;
    logic [14:0] crec;
    logic [6:0]  known;
    logic [6:0]  pos;

    logic [30:0] bl_dec;
    logic        bl_last;
    logic [63:0] acc_shift;
    logic [31:0] str_len;
    logic [6:0]  pos_len;
    logic [6:0]  fcount;
    logic        name_end;
    logic [3:0]  ft_type;
    logic        ft_known;
    logic        ft_last;
    trp_entry_t  ft_first;

    trp_entry_t  nxt_entry;
    logic        seek_more;
    logic        seek_wrap;
    logic        seek_done;

    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    trp_entry_t  ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [$bits(trp_entry_t)-1:0] ram_rdata;
    logic [6:0]  pos_inc;

    assign ph    = restart ? PH_CNT_HI : phase_reg;
    assign bl    = restart ? '0 : bytes_left_reg;
    assign cnt   = restart ? '0 : count_reg;
    assign kind  = restart ? '0 : kind_reg;
    assign nfld  = restart ? '0 : nfields_reg;
    assign cfld  = restart ? '0 : field_reg;
    assign crec  = restart ? '0 : record_reg;
    assign known = restart ? '0 : known_reg;
    assign pos   = restart ? '0 : pos_reg;

    assign bl_dec    = bl - 31'd1;
    assign bl_last   = (bl_dec == '0);
    assign acc_shift = {acc_reg[55:0], data_byte};
    assign str_len   = acc_shift[31] ? 32'd0 : acc_shift[31:0];
    assign pos_len   = data_byte[7] ? 7'd0 : data_byte[6:0];
    assign fcount    = (pos_len > FCAP) ? FCAP : pos_len;
    assign name_end  = cnt[15] || (cnt == '0);
    assign ft_type   = map_type(data_byte);
    assign ft_known  = (ft_type != VT_UNDEF);
    assign ft_last   = !(({1'b0, cfld} + 8'd1) < {1'b0, nfld});
    assign ft_first  = (known == '0) ? trp_entry_t'{field: cfld, vtype: ft_type} : first_reg;

    assign nxt_entry = fwd_hit_reg ? fwd_data_reg : trp_entry_t'(ram_rdata);
    assign seek_more = ({1'b0, pos} + 8'd1) < {1'b0, known};
    assign seek_wrap = !cnt[15] && (({1'b0, crec} + 16'd1) < {1'b0, cnt[14:0]});
    assign seek_done = !seek_more && !seek_wrap;

    assign ram_we    = step && (ph == PH_FTYPE) && ft_known;
    assign ram_waddr = known[AW-1:0];
    assign ram_wdata = trp_entry_t'{field: cfld, vtype: ft_type};
    assign pos_inc   = pos_next + 7'd1;
    assign ram_raddr = pos_inc[AW-1:0];
    assign fwd_hit_next = ram_we && (ram_waddr == ram_raddr);

    trp_ram #(
        .WIDTH ($bits(trp_entry_t)),
        .DEPTH (MAX_FIELDS)
    ) u_list (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        logic       sf_start;
        trp_entry_t sf_entry;

        sf_start = 1'b0;
        sf_entry = first_reg;

        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        count_next      = count_reg;
        kind_next       = kind_reg;
        nfields_next    = nfields_reg;
        field_next      = field_reg;
        record_next     = record_reg;
        ftype_next      = ftype_reg;
        known_next      = known_reg;
        pos_next        = pos_reg;
        first_next      = first_reg;
        acc_next        = acc_reg;

        if (step) begin
            phase_next      = ph;
            bytes_left_next = bl;
            count_next      = cnt;
            kind_next       = kind;
            nfields_next    = nfld;
            field_next      = cfld;
            record_next     = crec;
            known_next      = known;
            pos_next        = pos;

            unique case (ph)
                PH_CNT_HI: begin
                    count_next = {data_byte, 8'h00};
                    phase_next = PH_CNT_LO;
                end
                PH_CNT_LO: begin
                    count_next = {cnt[15:8], data_byte};
                    phase_next = PH_KIND;
                end
                PH_KIND: begin
                    kind_next  = data_byte;
                    phase_next = PH_NAME_LEN;
                end
                PH_NAME_LEN: begin
                    if (pos_len != '0) begin
                        bytes_left_next = {24'd0, pos_len};
                        phase_next      = PH_NAME;
                    end else begin
                        phase_next = name_end ? PH_DONE : PH_FCOUNT;
                    end
                end
                PH_NAME: begin
                    bytes_left_next = bl_dec;
                    if (bl_last) begin
                        phase_next = name_end ? PH_DONE : PH_FCOUNT;
                    end
                end
                PH_FCOUNT: begin
                    nfields_next = fcount;
                    field_next   = '0;
                    phase_next   = (fcount == '0) ? PH_DONE : PH_FNAME_LEN;
                end
                PH_FNAME_LEN: begin
                    bytes_left_next = {24'd0, pos_len};
                    phase_next      = (pos_len != '0) ? PH_FNAME : PH_FTYPE;
                end
                PH_FNAME: begin
                    bytes_left_next = bl_dec;
                    if (bl_last) begin
                        phase_next = PH_FTYPE;
                    end
                end
                PH_FTYPE: begin
                    if (ft_known) begin
                        known_next = known + 7'd1;
                    end
                    if (known == '0) begin
                        first_next = ft_first;
                    end
                    if (!ft_last) begin
                        field_next = cfld + 7'd1;
                        phase_next = PH_FNAME_LEN;
                    end else begin
                        record_next = '0;
                        if ((known != '0) || ft_known) begin
                            pos_next = '0;
                            sf_start = 1'b1;
                            sf_entry = ft_first;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_VALUE, PH_STR_LEN, PH_STR: begin
                    bytes_left_next = bl_dec;
                    if (ph != PH_STR) begin
                        acc_next = acc_shift;
                    end
                    if (bl_last) begin
                        if ((ph == PH_STR_LEN) && (str_len != '0)) begin
                            bytes_left_next = str_len[30:0];
                            phase_next      = PH_STR;
                        end else if (seek_more) begin
                            pos_next = pos + 7'd1;
                            sf_start = 1'b1;
                            sf_entry = nxt_entry;
                        end else if (seek_wrap) begin
                            record_next = crec + 15'd1;
                            pos_next    = '0;
                            sf_start    = 1'b1;
                            sf_entry    = first_reg;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase

            if (sf_start) begin
                field_next = sf_entry.field;
                ftype_next = sf_entry.vtype;
                acc_next   = '0;
                if (sf_entry.vtype == VT_STRING) begin
                    phase_next      = PH_STR_LEN;
                    bytes_left_next = STR_LEN_BYTES;
                end else begin
                    phase_next      = PH_VALUE;
                    bytes_left_next = type_width(sf_entry.vtype);
                end
            end
        end
    end

    // result
    always_comb begin
        res               = '0;
        res.record_count  = cnt;
        res.response_kind = kind;

        if (step) begin
            unique case (ph)
                PH_KIND: begin
                    res.emit          = 1'b1;
                    res.ev            = EV_HEADER;
                    res.response_kind = data_byte;
                end
                PH_NAME_LEN: begin
                    if ((pos_len == '0) && name_end) begin
                        res.emit = 1'b1;
                        res.ev   = EV_END;
                        res.done = 1'b1;
                    end
                end
                PH_NAME: begin
                    res.emit  = 1'b1;
                    res.ev    = EV_NAME_BYTE;
                    res.value = {56'd0, data_byte};
                    res.done  = bl_last && name_end;
                end
                PH_FCOUNT: begin
                    if (fcount == '0) begin
                        res.emit = 1'b1;
                        res.ev   = EV_END;
                        res.done = 1'b1;
                    end
                end
                PH_FNAME: begin
                    res.emit        = 1'b1;
                    res.ev          = EV_FNAME_BYTE;
                    res.value       = {56'd0, data_byte};
                    res.field_index = cfld;
                end
                PH_FTYPE: begin
                    res.emit        = 1'b1;
                    res.ev          = EV_FIELD_TYPE;
                    res.value       = {56'd0, data_byte};
                    res.field_index = cfld;
                    res.value_type  = ft_type;
                    res.done        = ft_last && (known == '0) && !ft_known;
                end
                PH_VALUE: begin
                    if (bl_last) begin
                        res.emit         = 1'b1;
                        res.ev           = EV_SCALAR;
                        res.value        = acc_shift;
                        res.record_index = crec;
                        res.field_index  = cfld;
                        res.value_type   = ftype_reg;
                        res.done         = seek_done;
                    end
                end
                PH_STR_LEN: begin
                    if (bl_last) begin
                        res.emit         = 1'b1;
                        res.ev           = EV_STR_LEN;
                        res.value        = {32'd0, str_len};
                        res.record_index = crec;
                        res.field_index  = cfld;
                        res.value_type   = VT_STRING;
                        res.done         = (str_len == '0) && seek_done;
                    end
                end
                PH_STR: begin
                    res.emit         = 1'b1;
                    res.ev           = EV_STR_BYTE;
                    res.value        = {56'd0, data_byte};
                    res.record_index = crec;
                    res.field_index  = cfld;
                    res.value_type   = VT_STRING;
                    res.done         = bl_last && seek_done;
                end
                default: begin
                    res.emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_CNT_HI;
            bytes_left_reg <= '0;
            count_reg      <= '0;
            kind_reg       <= '0;
            nfields_reg    <= '0;
            field_reg      <= '0;
            record_reg     <= '0;
            known_reg      <= '0;
            pos_reg        <= '0;
            fwd_hit_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            count_reg      <= count_next;
            kind_reg       <= kind_next;
            nfields_reg    <= nfields_next;
            field_reg      <= field_next;
            record_reg     <= record_next;
            known_reg      <= known_next;
            pos_reg        <= pos_next;
            fwd_hit_reg    <= fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        ftype_reg    <= ftype_next;
        first_reg    <= first_next;
        acc_reg      <= acc_next;
        fwd_data_reg <= ram_wdata;
    end

endmodule

// File: rtl/trp_out_reg.sv
`timescale 1ns / 1ps
// ============================================================================
// trp_out_reg
// Result register driving the master stream; frees itself as words are taken.
// ============================================================================
module trp_out_reg
    import trp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  trp_result_t   res,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [119:0]  m_tdata,
    output logic [2:0]    m_tuser,
    output logic          m_tlast,
    output logic          out_free
);

    logic        valid_reg, valid_next;
    trp_result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res.emit;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.emit) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.value_type, res_reg.field_index, res_reg.record_index,
                       res_reg.response_kind, res_reg.record_count, res_reg.value};
    assign m_tuser  = res_reg.ev;
    assign m_tlast  = res_reg.done;

endmodule

// File: rtl/typed_table_response_parser_top.sv
`timescale 1ns / 1ps
// ============================================================================
// typed_table_response_parser_top
// Byte-stream parser for typed table responses: header, field descriptors and
// per-record values, one result word per byte at most.
// ============================================================================
//  channel  dir  word content
//  s_       in   tdata: data_byte; tuser: restart
//  m_       out  tdata: value..value_type; tuser: event_res; tlast: message_done
//
//  One byte per cycle sustained while m_ is not stalled; each byte passes the
//  input register, then the result register, before its result word leaves.
//  The known-field list RAM read is prefetched, so record values keep pace.
//  Reset clears all control state; no clearing pass is needed.
//  A stall on m_ holds the result register and, once the input register is
//  also full, s_tready drops.
// ============================================================================
module typed_table_response_parser_top
    import trp_pkg::*;
#(
    parameter int MAX_FIELDS = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic [0:0]    s_tuser,   // [0] restart
    output logic          m_tvalid,
    input  logic          m_tready,
    // [63:0] value, [79:64] record_count, [87:80] response_kind,
    // [102:88] record_index, [109:103] field_index, [113:110] value_type
    output logic [119:0]  m_tdata,
    output logic [2:0]    m_tuser,   // [2:0] event_res
    output logic          m_tlast
);

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;
    logic        out_free;
    logic        step;
    logic        s_accept;
    trp_result_t res;

    assign step     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (step) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser[0];
        end
    end

    trp_parser #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .restart   (in_restart_reg),
        .res       (res)
    );

    trp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .out_free (out_free)
    );

endmodule

// File: rtl/trp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// trp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ============================================================================
module trp_checker
    import trp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [119:0]  m_tdata,
    input  logic [2:0]    m_tuser,
    input  logic          m_tlast
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_END) |-> m_tlast && (m_tdata[63:0] == '0))
        else $error("end word without message end");

    a_desc_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == EV_HEADER) || (m_tuser == EV_NAME_BYTE)
            || (m_tuser == EV_END)) |-> (m_tdata[113:88] == '0))
        else $error("indices set on a header word");

    a_string_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == EV_STR_LEN) || (m_tuser == EV_STR_BYTE))
            |-> (m_tdata[113:110] == VT_STRING))
        else $error("string word without string type");

endmodule

bind typed_table_response_parser_top trp_checker u_trp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
